// ----- rtl/oldiff_pkg.sv -----
`timescale 1ns / 1ps
// Package for the orbital list difference block: field widths, result kinds,
// step unit opcodes and the control structs shared by the step unit and the sequencer.
// No dependencies.
package oldiff_pkg;

   localparam int MAX_ORBITALS_DEF = 16;
   localparam int ORB_W            = 8;
   localparam int SIGN_W           = 16;
   localparam int DIFF_W           = 6;
   localparam int KIND_W           = 2;
   localparam int ABORT_TOTAL      = 4;
   localparam int ABORT_TAIL       = 3;
   localparam int CSR_ADDR_W       = 2;
   localparam int CSR_DATA_W       = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_COMMON  = 2'd0,
      KIND_FIRST   = 2'd1,
      KIND_SECOND  = 2'd2,
      KIND_SUMMARY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_MERGE       = 2'd0,
      OP_CHECK       = 2'd1,
      OP_TAIL_FIRST  = 2'd2,
      OP_TAIL_SECOND = 2'd3
   } step_op_type;

   typedef struct packed {
      step_op_type op;
      logic        ext;
   } step_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     abort;
      logic     tail_first;
      logic     tail_second;
   } step_flag_type;

endpackage

// ----- rtl/oldiff_step.sv -----
`timescale 1ns / 1ps
// Shared merge step unit: one compare, one counter update and one flip add per use.
// Depends on oldiff_pkg.
module oldiff_step #(
   parameter int CNT_W = 5
) (
   input  oldiff_pkg::step_cmd_type         cmd,
   input  logic [oldiff_pkg::ORB_W-1:0]     a,
   input  logic [oldiff_pkg::ORB_W-1:0]     b,
   input  logic [CNT_W-1:0]                 i_cur,
   input  logic [CNT_W-1:0]                 j_cur,
   input  logic [CNT_W-1:0]                 icnt_cur,
   input  logic [CNT_W-1:0]                 jcnt_cur,
   input  logic [oldiff_pkg::SIGN_W-1:0]    flips_cur,
   output logic [CNT_W-1:0]                 i_nx,
   output logic [CNT_W-1:0]                 j_nx,
   output logic [CNT_W-1:0]                 icnt_nx,
   output logic [CNT_W-1:0]                 jcnt_nx,
   output logic [oldiff_pkg::SIGN_W-1:0]    flips_nx,
   output logic [oldiff_pkg::ORB_W-1:0]     orbital,
   output oldiff_pkg::step_flag_type        flag
);
   import oldiff_pkg::*;

   logic over_total;

   assign over_total = (int'(icnt_cur) + int'(jcnt_cur) + 1) > ABORT_TOTAL;

   always_comb begin
      i_nx     = i_cur;
      j_nx     = j_cur;
      icnt_nx  = icnt_cur;
      jcnt_nx  = jcnt_cur;
      flips_nx = flips_cur;
      orbital  = a;
      flag     = '{kind: KIND_COMMON, abort: 1'b0, tail_first: 1'b0, tail_second: 1'b0};
      unique case (cmd.op)
         OP_MERGE: begin
            if (a == b) begin
               i_nx = i_cur + CNT_W'(1);
               j_nx = j_cur + CNT_W'(1);
            end else if (a < b) begin
               flag.kind  = KIND_FIRST;
               flips_nx   = flips_cur + SIGN_W'(i_cur - icnt_cur);
               icnt_nx    = icnt_cur + CNT_W'(1);
               i_nx       = i_cur + CNT_W'(1);
               flag.abort = !cmd.ext && over_total;
            end else begin
               flag.kind  = KIND_SECOND;
               orbital    = b;
               flips_nx   = flips_cur + SIGN_W'(j_cur - jcnt_cur);
               jcnt_nx    = jcnt_cur + CNT_W'(1);
               j_nx       = j_cur + CNT_W'(1);
               flag.abort = !cmd.ext && over_total;
            end
         end
         OP_CHECK: begin
            if (i_cur < j_cur) begin
               if (!cmd.ext && (int'(j_cur) - int'(i_cur) + int'(icnt_cur)) >= ABORT_TAIL) begin
                  flag.abort = 1'b1;
               end else begin
                  flag.tail_first = 1'b1;
               end
            end else if (j_cur < i_cur) begin
               if (!cmd.ext && (int'(i_cur) - int'(j_cur) + int'(jcnt_cur)) >= ABORT_TAIL) begin
                  flag.abort = 1'b1;
               end else begin
                  flag.tail_second = 1'b1;
               end
            end
         end
         OP_TAIL_FIRST: begin
            flag.kind = KIND_FIRST;
            flips_nx  = flips_cur + SIGN_W'(i_cur - icnt_cur);
            icnt_nx   = icnt_cur + CNT_W'(1);
            i_nx      = i_cur + CNT_W'(1);
         end
         OP_TAIL_SECOND: begin
            flag.kind = KIND_SECOND;
            orbital   = b;
            flips_nx  = flips_cur + SIGN_W'(j_cur - jcnt_cur);
            jcnt_nx   = jcnt_cur + CNT_W'(1);
            j_nx      = j_cur + CNT_W'(1);
         end
         default: begin
            flag.abort = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/oldiff_lists.sv -----
`timescale 1ns / 1ps
// Storage for the two orbital lists: one write port for both, one read port per list.
// Depends on oldiff_pkg.
module oldiff_lists #(
   parameter int MAX_ORB = 16,
   parameter int IDX_W   = 4
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [IDX_W-1:0]                 wr_addr,
   input  logic [oldiff_pkg::ORB_W-1:0]     wr_first,
   input  logic [oldiff_pkg::ORB_W-1:0]     wr_second,
   input  logic [IDX_W-1:0]                 rd_first_addr,
   input  logic [IDX_W-1:0]                 rd_second_addr,
   output logic [oldiff_pkg::ORB_W-1:0]     rd_first,
   output logic [oldiff_pkg::ORB_W-1:0]     rd_second
);
   import oldiff_pkg::*;

   logic [ORB_W-1:0] first_ff  [MAX_ORB];
   logic [ORB_W-1:0] second_ff [MAX_ORB];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         first_ff[wr_addr]  <= wr_first;
         second_ff[wr_addr] <= wr_second;
      end
   end

   assign rd_first  = first_ff[rd_first_addr];
   assign rd_second = second_ff[rd_second_addr];

endmodule

// ----- rtl/oldiff_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: list loading, scan pass and emit pass over the shared step unit, result register.
// Depends on oldiff_pkg and oldiff_step.
module oldiff_ctrl #(
   parameter int MAX_ORB = 16,
   parameter int CNT_W   = 5,
   parameter int IDX_W   = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [oldiff_pkg::SIGN_W-1:0]    sign_in,
   input  logic                             is_last,
   input  logic                             ext_mode,
   output logic                             wr_en,
   output logic [IDX_W-1:0]                 wr_addr,
   output logic [IDX_W-1:0]                 rd_first_addr,
   output logic [IDX_W-1:0]                 rd_second_addr,
   input  logic [oldiff_pkg::ORB_W-1:0]     rd_first,
   input  logic [oldiff_pkg::ORB_W-1:0]     rd_second,
   output logic                             rsp_valid,
   output oldiff_pkg::kind_type             rsp_kind,
   output logic [oldiff_pkg::ORB_W-1:0]     rsp_orbital,
   output logic signed [oldiff_pkg::DIFF_W-1:0] rsp_diff_count,
   output logic [oldiff_pkg::SIGN_W-1:0]    rsp_sign_out,
   output logic                             rsp_run_end
);
   import oldiff_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MERGE = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_TAIL  = 5'b01000,
      ST_SUM   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] load_ff, load_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, icnt_ff, icnt_in, jcnt_ff, jcnt_in;
   logic [SIGN_W-1:0] flips_ff, flips_in, sign_ff, sign_in_nx;
   logic             pass_ff, pass_in, abort_ff, abort_in, tail_first_ff, tail_first_in;
   logic             valid_ff, valid_in, end_ff, end_in;
   kind_type         kind_ff, kind_in;
   logic [ORB_W-1:0] orb_ff, orb_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;
   logic [SIGN_W-1:0] sout_ff, sout_in;

   step_cmd_type     cmd;
   step_flag_type    flag;
   logic [CNT_W-1:0] i_nx, j_nx, icnt_nx, jcnt_nx;
   logic [SIGN_W-1:0] flips_nx;
   logic [ORB_W-1:0] step_orb;
   logic             room, in_range, tail_more, take;

   oldiff_step #(.CNT_W(CNT_W)) u_step (
      .cmd       (cmd),
      .a         (rd_first),
      .b         (rd_second),
      .i_cur     (i_ff),
      .j_cur     (j_ff),
      .icnt_cur  (icnt_ff),
      .jcnt_cur  (jcnt_ff),
      .flips_cur (flips_ff),
      .i_nx      (i_nx),
      .j_nx      (j_nx),
      .icnt_nx   (icnt_nx),
      .jcnt_nx   (jcnt_nx),
      .flips_nx  (flips_nx),
      .orbital   (step_orb),
      .flag      (flag)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign take           = start && !busy;
   assign room           = int'(load_ff) < MAX_ORB;
   assign wr_en          = take && room;
   assign wr_addr        = load_ff[IDX_W-1:0];
   assign rd_first_addr  = i_ff[IDX_W-1:0];
   assign rd_second_addr = j_ff[IDX_W-1:0];
   assign in_range       = (i_ff < n_ff) && (j_ff < n_ff);
   assign tail_more      = tail_first_ff ? (i_ff < n_ff) : (j_ff < n_ff);

   always_comb begin
      cmd.ext = ext_mode;
      unique case (state_ff)
         ST_CHECK: cmd.op = OP_CHECK;
         ST_TAIL:  cmd.op = tail_first_ff ? OP_TAIL_FIRST : OP_TAIL_SECOND;
         default:  cmd.op = OP_MERGE;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      load_in       = load_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      icnt_in       = icnt_ff;
      jcnt_in       = jcnt_ff;
      flips_in      = flips_ff;
      sign_in_nx    = sign_ff;
      pass_in       = pass_ff;
      abort_in      = abort_ff;
      tail_first_in = tail_first_ff;
      valid_in      = 1'b0;
      kind_in       = kind_ff;
      orb_in        = orb_ff;
      diff_in       = diff_ff;
      sout_in       = sout_ff;
      end_in        = end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (room) begin
                  load_in = load_ff + CNT_W'(1);
               end
               if (is_last) begin
                  n_in       = room ? load_ff + CNT_W'(1) : load_ff;
                  load_in    = '0;
                  sign_in_nx = sign_in;
                  i_in       = '0;
                  j_in       = '0;
                  icnt_in    = '0;
                  jcnt_in    = '0;
                  flips_in   = '0;
                  pass_in    = 1'b0;
                  abort_in   = 1'b0;
                  state_in   = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            if (in_range) begin
               i_in     = i_nx;
               j_in     = j_nx;
               icnt_in  = icnt_nx;
               jcnt_in  = jcnt_nx;
               flips_in = flips_nx;
               if (flag.abort) begin
                  abort_in = 1'b1;
                  state_in = ST_SUM;
               end else if (pass_ff) begin
                  valid_in = 1'b1;
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            tail_first_in = flag.tail_first;
            if (flag.abort) begin
               abort_in = 1'b1;
               state_in = ST_SUM;
            end else if (flag.tail_first || flag.tail_second) begin
               state_in = ST_TAIL;
            end else if (pass_ff) begin
               state_in = ST_SUM;
            end else begin
               pass_in  = 1'b1;
               i_in     = '0;
               j_in     = '0;
               icnt_in  = '0;
               jcnt_in  = '0;
               flips_in = '0;
               state_in = ST_MERGE;
            end
         end
         ST_TAIL: begin
            if (tail_more) begin
               i_in     = i_nx;
               j_in     = j_nx;
               icnt_in  = icnt_nx;
               jcnt_in  = jcnt_nx;
               flips_in = flips_nx;
               valid_in = pass_ff;
            end else if (pass_ff) begin
               state_in = ST_SUM;
            end else begin
               pass_in  = 1'b1;
               i_in     = '0;
               j_in     = '0;
               icnt_in  = '0;
               jcnt_in  = '0;
               flips_in = '0;
               state_in = ST_MERGE;
            end
         end
         ST_SUM: begin
            valid_in = 1'b1;
            kind_in  = KIND_SUMMARY;
            orb_in   = '0;
            diff_in  = abort_ff ? '1 : DIFF_W'(icnt_ff);
            sout_in  = abort_ff ? sign_ff : sign_ff + flips_ff;
            end_in   = 1'b1;
            abort_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (valid_in && state_ff != ST_SUM) begin
         kind_in = flag.kind;
         orb_in  = step_orb;
         diff_in = '0;
         sout_in = '0;
         end_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         load_ff  <= '0;
         sign_ff  <= '0;
         pass_ff  <= 1'b0;
         abort_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         sign_ff  <= sign_in_nx;
         pass_ff  <= pass_in;
         abort_ff <= abort_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      icnt_ff       <= icnt_in;
      jcnt_ff       <= jcnt_in;
      flips_ff      <= flips_in;
      tail_first_ff <= tail_first_in;
      kind_ff       <= kind_in;
      orb_ff        <= orb_in;
      diff_ff       <= diff_in;
      sout_ff       <= sout_in;
      end_ff        <= end_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_orbital    = orb_ff;
   assign rsp_diff_count = signed'(diff_ff);
   assign rsp_sign_out   = sout_ff;
   assign rsp_run_end    = end_ff;

endmodule

// ----- rtl/orbital_list_difference.sv -----
`timescale 1ns / 1ps
// Top level of the orbital list difference block: configuration register and instances.
// Depends on oldiff_pkg, oldiff_lists and oldiff_ctrl.
//
// Usage: drive req_* with start high while busy is low; each such cycle takes one request,
// a pair of entries of the two sorted lists. Requests without req_is_last store the pair, if
// the lists have room, and return nothing. A request with req_is_last starts the comparison:
// a scan pass of the shared step unit, one merge step per cycle, decides whether the run
// aborts; if not, an emit pass repeats the steps and presents one result per step, then a
// summary (rsp_kind summary, rsp_run_end high). An aborted run presents only the summary.
// The last request keeps busy high until the summary, as the whole comparison runs on the
// single step unit.
// Results appear for one cycle each, flagged by rsp_valid; the receiver cannot stall them.
// extended_mode is bit 0 of the APB port, which does not decode paddr; write it only while busy is low.
// Reset clears the sequencer, the load count and extended_mode; list contents are kept.
module orbital_list_difference #(
   parameter int MAX_ORBITALS = oldiff_pkg::MAX_ORBITALS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [oldiff_pkg::ORB_W-1:0]          req_i_orbital,
   input  logic [oldiff_pkg::ORB_W-1:0]          req_j_orbital,
   input  logic [oldiff_pkg::SIGN_W-1:0]         req_sign_in,
   input  logic                                  req_is_last,
   output logic                                  rsp_valid,
   output logic [oldiff_pkg::KIND_W-1:0]         rsp_kind,
   output logic [oldiff_pkg::ORB_W-1:0]          rsp_orbital,
   output logic signed [oldiff_pkg::DIFF_W-1:0]  rsp_diff_count,
   output logic [oldiff_pkg::SIGN_W-1:0]         rsp_sign_out,
   output logic                                  rsp_run_end,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [oldiff_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [oldiff_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [oldiff_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                  pready
);
   import oldiff_pkg::*;

   localparam int CNT_W = $clog2(MAX_ORBITALS + 1);
   localparam int IDX_W = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;

   logic             ext_ff, ext_in;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_first_addr, rd_second_addr;
   logic [ORB_W-1:0] rd_first, rd_second;
   kind_type         kind;

   assign pready = 1'b1;
   assign ext_in = (psel && penable && pwrite && pready) ? pwdata[0] : ext_ff;
   assign prdata = {{(CSR_DATA_W-1){1'b0}}, ext_ff} | {{(CSR_DATA_W-CSR_ADDR_W){1'b0}},
                   paddr & {CSR_ADDR_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= 1'b0;
      end else begin
         ext_ff <= ext_in;
      end
   end

   oldiff_lists #(.MAX_ORB(MAX_ORBITALS), .IDX_W(IDX_W)) u_lists (
      .clock          (clock),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_first       (req_i_orbital),
      .wr_second      (req_j_orbital),
      .rd_first_addr  (rd_first_addr),
      .rd_second_addr (rd_second_addr),
      .rd_first       (rd_first),
      .rd_second      (rd_second)
   );

   oldiff_ctrl #(.MAX_ORB(MAX_ORBITALS), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .sign_in        (req_sign_in),
      .is_last        (req_is_last),
      .ext_mode       (ext_ff),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .rd_first_addr  (rd_first_addr),
      .rd_second_addr (rd_second_addr),
      .rd_first       (rd_first),
      .rd_second      (rd_second),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (kind),
      .rsp_orbital    (rsp_orbital),
      .rsp_diff_count (rsp_diff_count),
      .rsp_sign_out   (rsp_sign_out),
      .rsp_run_end    (rsp_run_end)
   );

   assign rsp_kind = kind;

endmodule

// ----- tb/orbital_diff_monitor.sv -----
`timescale 1ns / 1ps
// Result checker for orbital_list_difference: tracks the list store, the extended_mode
// register and the merge, and compares every result strobe with the predicted one.
// Depends on oldiff_pkg.
module orbital_diff_monitor #(
   parameter logic [oldiff_pkg::CSR_ADDR_W-1:0] EXT_MODE_ADDR = '0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [oldiff_pkg::ORB_W-1:0]         req_i_orbital,
   input  logic [oldiff_pkg::ORB_W-1:0]         req_j_orbital,
   input  logic [oldiff_pkg::SIGN_W-1:0]        req_sign_in,
   input  logic                                 req_is_last,
   input  logic                                 rsp_valid,
   input  logic [oldiff_pkg::KIND_W-1:0]        rsp_kind,
   input  logic [oldiff_pkg::ORB_W-1:0]         rsp_orbital,
   input  logic signed [oldiff_pkg::DIFF_W-1:0] rsp_diff_count,
   input  logic [oldiff_pkg::SIGN_W-1:0]        rsp_sign_out,
   input  logic                                 rsp_run_end,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [oldiff_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [oldiff_pkg::CSR_DATA_W-1:0]    pwdata,
   input  logic                                 pready,
   output int                                   mismatch_count,
   output int                                   pending_count
);
   import oldiff_pkg::*;

   localparam int LIST_DEPTH = MAX_ORBITALS_DEF;

   typedef struct packed {
      kind_type                  kind;
      logic [ORB_W-1:0]          orbital;
      logic signed [DIFF_W-1:0]  diff_count;
      logic [SIGN_W-1:0]         sign_out;
      logic                      run_end;
   } orbital_result_type;

   logic [ORB_W-1:0]    first_held [LIST_DEPTH];
   logic [ORB_W-1:0]    second_held [LIST_DEPTH];
   int                  held_pairs;
   logic                ext_mode;
   orbital_result_type  predicted_results [$];
   orbital_result_type  observed;
   orbital_result_type  wanted;

   function automatic orbital_result_type orbital_entry(kind_type k, logic [ORB_W-1:0] orb);
      orbital_result_type r;
      r = '0;
      r.kind = k;
      r.orbital = orb;
      return r;
   endfunction

   task automatic merge_request(input logic [ORB_W-1:0] i_orb, input logic [ORB_W-1:0] j_orb,
                                input logic [SIGN_W-1:0] sign, input logic last);
      orbital_result_type run_out [$];
      orbital_result_type closing;
      logic [SIGN_W-1:0]  flips;
      int                 n;
      int                 ia;
      int                 ib;
      int                 a_only;
      int                 b_only;
      bit                 quit;
      if (held_pairs < LIST_DEPTH) begin
         first_held[held_pairs] = i_orb;
         second_held[held_pairs] = j_orb;
         held_pairs++;
      end
      if (!last) return;
      n = held_pairs;
      held_pairs = 0;
      ia = 0;
      ib = 0;
      a_only = 0;
      b_only = 0;
      flips = '0;
      quit = 0;
      while (ia < n && ib < n && !quit) begin
         if (first_held[ia] == second_held[ib]) begin
            run_out.push_back(orbital_entry(KIND_COMMON, first_held[ia]));
            ia++;
            ib++;
         end else if (first_held[ia] < second_held[ib]) begin
            run_out.push_back(orbital_entry(KIND_FIRST, first_held[ia]));
            flips += SIGN_W'(ia - a_only);
            a_only++;
            ia++;
            if (a_only + b_only > ABORT_TOTAL && !ext_mode) quit = 1;
         end else begin
            run_out.push_back(orbital_entry(KIND_SECOND, second_held[ib]));
            flips += SIGN_W'(ib - b_only);
            b_only++;
            ib++;
            if (a_only + b_only > ABORT_TOTAL && !ext_mode) quit = 1;
         end
      end
      if (!quit && ia < ib) begin
         if (ib - ia + a_only >= ABORT_TAIL && !ext_mode) begin
            quit = 1;
         end else begin
            while (ia < n) begin
               run_out.push_back(orbital_entry(KIND_FIRST, first_held[ia]));
               flips += SIGN_W'(ia - a_only);
               a_only++;
               ia++;
            end
         end
      end else if (!quit && ib < ia) begin
         if (ia - ib + b_only >= ABORT_TAIL && !ext_mode) begin
            quit = 1;
         end else begin
            while (ib < n) begin
               run_out.push_back(orbital_entry(KIND_SECOND, second_held[ib]));
               flips += SIGN_W'(ib - b_only);
               b_only++;
               ib++;
            end
         end
      end
      closing = orbital_entry(KIND_SUMMARY, '0);
      closing.run_end = 1'b1;
      if (quit) begin
         // drop the partial lists
         run_out.delete();
         closing.diff_count = -1;
         closing.sign_out = sign;
      end else begin
         closing.diff_count = DIFF_W'(a_only);
         closing.sign_out = sign + flips;
      end
      run_out.push_back(closing);
      foreach (run_out[k]) predicted_results.push_back(run_out[k]);
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected kind=%0d orbital=%0d diff=%0d sign=%0d end=%0d,",
                  $realtime, what, wanted.kind, wanted.orbital, wanted.diff_count,
                  wanted.sign_out, wanted.run_end);
         $display("   got kind=%0d orbital=%0d diff=%0d sign=%0d end=%0d",
                  observed.kind, observed.orbital, observed.diff_count,
                  observed.sign_out, observed.run_end);
      end
   endtask

   initial begin
      mismatch_count = 0;
      pending_count = 0;
      held_pairs = 0;
      ext_mode = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         predicted_results.delete();
         held_pairs = 0;
         ext_mode = 1'b0;
      end else begin
         if (rsp_valid) begin
            observed.kind = kind_type'(rsp_kind);
            observed.orbital = rsp_orbital;
            observed.diff_count = rsp_diff_count;
            observed.sign_out = rsp_sign_out;
            observed.run_end = rsp_run_end;
            if (predicted_results.size() == 0) begin
               wanted = '0;
               report_mismatch("unexpected result");
            end else begin
               wanted = predicted_results.pop_front();
               if (wanted.kind !== observed.kind || wanted.orbital !== observed.orbital ||
                   wanted.diff_count !== observed.diff_count ||
                   wanted.sign_out !== observed.sign_out ||
                   wanted.run_end !== observed.run_end)
                  report_mismatch("result differs");
            end
         end
         if (psel && penable && pwrite && pready && paddr == EXT_MODE_ADDR)
            ext_mode = pwdata[0];
         if (start && !busy)
            merge_request(req_i_orbital, req_j_orbital, req_sign_in, req_is_last);
      end
      pending_count <= predicted_results.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the orbital_list_difference testbench: clock, reset, request and register
// stimulus, watchdog and verdict. Depends on oldiff_pkg, orbital_diff_monitor and the block.
module testbench;
   import oldiff_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] EXT_MODE_ADDR = '0;
   localparam int SETTLE_CYCLES  = 4 * MAX_ORBITALS_DEF + 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RUN_ITEMS      = 42;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [ORB_W-1:0]          req_i_orbital;
   logic [ORB_W-1:0]          req_j_orbital;
   logic [SIGN_W-1:0]         req_sign_in;
   logic                      req_is_last;
   logic                      rsp_valid;
   logic [KIND_W-1:0]         rsp_kind;
   logic [ORB_W-1:0]          rsp_orbital;
   logic signed [DIFF_W-1:0]  rsp_diff_count;
   logic [SIGN_W-1:0]         rsp_sign_out;
   logic                      rsp_run_end;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_W-1:0]     paddr;
   logic [CSR_DATA_W-1:0]     pwdata;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;
   int                        mismatch_count;
   int                        pending_count;
   int                        idle_cycles;
   int                        burst_left;
   logic [ORB_W-1:0]          pair_first [32];
   logic [ORB_W-1:0]          pair_second [32];

   orbital_list_difference DUT (
      .clock, .reset, .start, .busy,
      .req_i_orbital, .req_j_orbital, .req_sign_in, .req_is_last,
      .rsp_valid, .rsp_kind, .rsp_orbital, .rsp_diff_count, .rsp_sign_out, .rsp_run_end,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   orbital_diff_monitor #(.EXT_MODE_ADDR(EXT_MODE_ADDR)) u_monitor (
      .clock, .reset, .start, .busy,
      .req_i_orbital, .req_j_orbital, .req_sign_in, .req_is_last,
      .rsp_valid, .rsp_kind, .rsp_orbital, .rsp_diff_count, .rsp_sign_out, .rsp_run_end,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatch_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // hold the sender off between bursts
   task automatic pace();
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
   endtask

   task automatic issue(input logic [ORB_W-1:0] i_orb, input logic [ORB_W-1:0] j_orb,
                        input logic [SIGN_W-1:0] sign, input logic last);
      pace();
      start <= 1'b1;
      req_i_orbital <= i_orb;
      req_j_orbital <= j_orb;
      req_sign_in <= sign;
      req_is_last <= last;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_run(input int len, input logic [SIGN_W-1:0] sign);
      for (int p = 0; p < len; p++)
         issue(pair_first[p], pair_second[p],
               (p == len - 1) ? sign : SIGN_W'($urandom_range(0, 65535)), p == len - 1);
   endtask

   // drop start and wait until every predicted result has come back
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ext_mode(input logic value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= EXT_MODE_ADDR;
      pwdata <= {{(CSR_DATA_W-1){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic sort_pairs(input int n);
      logic [ORB_W-1:0] hold;
      int               q;
      for (int p = 1; p < n; p++) begin
         hold = pair_first[p];
         for (q = p; q > 0 && pair_first[q-1] > hold; q--) pair_first[q] = pair_first[q-1];
         pair_first[q] = hold;
         hold = pair_second[p];
         for (q = p; q > 0 && pair_second[q-1] > hold; q--) pair_second[q] = pair_second[q-1];
         pair_second[q] = hold;
      end
   endtask

   // two sorted lists of distinct orbitals that differ in d places
   task automatic build_sorted_lists(input int n, input int d);
      bit taken [256];
      int ceiling;
      int v;
      foreach (taken[k]) taken[k] = 0;
      ceiling = $urandom_range(0, 1) ? 255 : 40;
      for (int k = 0; k < n; k++) begin
         do v = $urandom_range(0, ceiling); while (taken[v]);
         taken[v] = 1;
         pair_first[k] = ORB_W'(v);
         pair_second[k] = ORB_W'(v);
      end
      for (int k = 0; k < d; k++) begin
         do v = $urandom_range(0, ceiling); while (taken[v]);
         taken[v] = 1;
         pair_second[k] = ORB_W'(v);
      end
      sort_pairs(n);
   endtask

   task automatic random_phase(input int item_goal);
      int items;
      int n;
      int style;
      logic [SIGN_W-1:0] sign;
      items = 0;
      while (items < item_goal) begin
         style = $urandom_range(0, 9);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
         case (style)
            7: begin
               // unsorted lists with repeats
               for (int k = 0; k < n; k++) begin
                  pair_first[k] = ORB_W'($urandom_range(0, 7));
                  pair_second[k] = ORB_W'($urandom_range(0, 255));
                  if ($urandom_range(0, 1)) pair_second[k] = ORB_W'($urandom_range(0, 7));
               end
            end
            8: begin
               // more pairs than the lists hold
               n = $urandom_range(17, 20);
               build_sorted_lists(MAX_ORBITALS_DEF, $urandom_range(0, 4));
               for (int k = MAX_ORBITALS_DEF; k < n; k++) begin
                  pair_first[k] = ORB_W'($urandom_range(0, 255));
                  pair_second[k] = ORB_W'($urandom_range(0, 255));
               end
            end
            9: build_sorted_lists(n, 0);
            default: build_sorted_lists(n, $urandom_range(0, (n < 4) ? n : 4));
         endcase
         case ($urandom_range(0, 5))
            0: sign = '0;
            1: sign = '1;
            default: sign = SIGN_W'($urandom_range(0, 65535));
         endcase
         send_run(n, sign);
         items += n;
         if ($urandom_range(0, 9) == 0) drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_i_orbital = '0;
      req_j_orbital = '0;
      req_sign_in = '0;
      req_is_last = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      idle_cycles = 0;
      burst_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_ext_mode(1'b0);

      pair_first[0] = 8'd0;
      pair_second[0] = 8'd0;
      send_run(1, 16'h0000);
      pair_first[0] = 8'd1;
      pair_first[1] = 8'd3;
      pair_second[0] = 8'd1;
      pair_second[1] = 8'd2;
      send_run(2, 16'hFFFF);
      // tail leaves three orbitals on one side
      pair_first[0] = 8'd1;
      pair_first[1] = 8'd2;
      pair_first[2] = 8'd3;
      pair_second[0] = 8'd250;
      pair_second[1] = 8'd254;
      pair_second[2] = 8'd255;
      send_run(3, 16'h1234);
      // more than four differences during the merge
      pair_first[0] = 8'd1;
      pair_first[1] = 8'd3;
      pair_first[2] = 8'd5;
      pair_second[0] = 8'd2;
      pair_second[1] = 8'd4;
      pair_second[2] = 8'd6;
      send_run(3, 16'h8001);
      // one pair past the list capacity
      for (int k = 0; k <= MAX_ORBITALS_DEF; k++) begin
         pair_first[k] = ORB_W'(k * 15);
         pair_second[k] = ORB_W'(k * 15 + ((k == 3) ? 1 : 0));
      end
      send_run(MAX_ORBITALS_DEF + 1, 16'h00FF);
      drain();

      write_ext_mode(1'b1);
      random_phase(RUN_ITEMS);
      drain();
      write_ext_mode(1'b0);
      random_phase(RUN_ITEMS);
      drain();
      write_ext_mode(1'b1);
      random_phase(RUN_ITEMS);
      drain();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/oldiff_pkg.sv
rtl/oldiff_step.sv
rtl/oldiff_lists.sv
rtl/oldiff_ctrl.sv
rtl/orbital_list_difference.sv
tb/orbital_diff_monitor.sv
tb/testbench.sv
